FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the memory access core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

FILE: hdl/sema_pkg.sv
// ----------------------------------------------------------------------------
// sema_pkg
// Types, codes and lane helpers for the sized endian memory access core.
// ----------------------------------------------------------------------------
`default_nettype none

package sema_pkg;

   localparam int MEM_BYTES = 65536;
   localparam int LANES     = 4;
   localparam int ADDR_W    = $clog2(MEM_BYTES);
   localparam int ROW_W     = ADDR_W - 2;
   localparam int ROW_DEPTH = MEM_BYTES / LANES;

   // Result status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_ALIGN = 2'd2;

   // Access size codes.
   localparam logic [1:0] SZ_BYTE = 2'd0;
   localparam logic [1:0] SZ_HALF = 2'd1;
   localparam logic [1:0] SZ_WORD = 2'd2;
   localparam logic [1:0] SZ_RSVD = 2'd3;

   // Access kinds.
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_BIG_ENDIAN = 1'b0;
   localparam logic CSR_MEM_SIZE   = 1'b1;

   typedef struct packed {
      logic [1:0]                  status;
      logic                        read_go;
      logic [LANES-1:0]            lane_we;
      logic [LANES-1:0][7:0]       lane_data;
      logic [ROW_W-1:0]            row;
   } decode_type;

   typedef struct packed {
      logic       read_ok;
      logic [1:0] size;
      logic [1:0] base;
      logic       big_endian;
      logic [1:0] status;
   } ctl_type;

   // Byte count minus one, used as the alignment mask.
   function automatic logic [1:0] size_mask(input logic [1:0] size);
      logic [1:0] m;
      case (size)
         SZ_BYTE: m = 2'd0;
         SZ_HALF: m = 2'd1;
         default: m = 2'd3;
      endcase
      return m;
   endfunction

   // True when a lane carries a byte of an aligned access.
   function automatic logic lane_active(input logic [1:0] lane, input logic [1:0] base,
                                        input logic [1:0] size);
      logic [1:0] m;
      m = size_mask(size);
      return (lane & ~m) == (base & ~m);
   endfunction

   // Byte position within the value for the byte held in a lane.
   function automatic logic [1:0] lane_pos(input logic [1:0] lane, input logic [1:0] size,
                                           input logic be);
      logic [1:0] m;
      logic [1:0] i;
      m = size_mask(size);
      i = lane & m;
      return be ? (m - i) : i;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/sema_lane_ram.sv
// ----------------------------------------------------------------------------
// sema_lane_ram
// Single-port RAM for one byte lane with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sema_lane_ram #(
   parameter int DEPTH = 16384,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     re,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: hdl/sema_decode.sv
// ----------------------------------------------------------------------------
// sema_decode
// Range and alignment checks, lane write enables and lane write data.
// ----------------------------------------------------------------------------
`default_nettype none

module sema_decode (
   input  wire logic               kind,
   input  wire logic [1:0]         access_size,
   input  wire logic [31:0]        address,
   input  wire logic [31:0]        write_data,
   input  wire logic               big_endian,
   input  wire logic [16:0]        mem_size,
   output sema_pkg::decode_type    dec
);
   import sema_pkg::*;

   logic [32:0] limit;
   logic [32:0] last_byte;
   logic [1:0]  mask;
   logic        range_bad;
   logic        align_bad;
   logic        rsvd;
   logic [LANES-1:0] lane_out;
   logic [LANES-1:0] lane_on;

   always_comb begin
      // A size setting beyond the store acts as the full store.
      if (33'(mem_size) > 33'(MEM_BYTES)) begin
         limit = 33'(MEM_BYTES);
      end else begin
         limit = 33'(mem_size);
      end
      mask      = size_mask(access_size);
      last_byte = {1'b0, address} + 33'(mask);
      range_bad = last_byte >= limit;
      align_bad = (address[1:0] & mask) != 2'd0;
      rsvd      = access_size == SZ_RSVD;

      for (int l = 0; l < LANES; l++) begin
         lane_on[l]  = lane_active(2'(l), address[1:0], access_size);
         lane_out[l] = {1'b0, address[31:2], 2'(l)} >= limit;
         dec.lane_data[l] = write_data[8*lane_pos(2'(l), access_size, big_endian) +: 8];
         dec.lane_we[l]   = (kind == KIND_WRITE) && !rsvd && !align_bad
                            && lane_on[l] && !lane_out[l];
      end

      if (rsvd) begin
         dec.status = ST_ALIGN;
      end else if (kind == KIND_READ) begin
         dec.status = range_bad ? ST_RANGE : (align_bad ? ST_ALIGN : ST_OK);
      end else begin
         dec.status = align_bad ? ST_ALIGN : ((|(lane_on & lane_out)) ? ST_RANGE : ST_OK);
      end

      dec.read_go = (kind == KIND_READ) && (dec.status == ST_OK);
      dec.row     = address[ADDR_W-1:2];
   end

endmodule

`default_nettype wire

FILE: hdl/sema_assemble.sv
// ----------------------------------------------------------------------------
// sema_assemble
// Builds the zero-extended read value from the lane bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module sema_assemble (
   input  wire sema_pkg::ctl_type             ctl,
   input  wire logic [sema_pkg::LANES-1:0][7:0] lane_bytes,
   output logic      [31:0]                   read_data
);
   import sema_pkg::*;

   always_comb begin
      read_data = '0;
      if (ctl.read_ok) begin
         for (int l = 0; l < LANES; l++) begin
            if (lane_active(2'(l), ctl.base, ctl.size)) begin
               read_data[8*lane_pos(2'(l), ctl.size, ctl.big_endian) +: 8] = lane_bytes[l];
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: hdl/sized_endian_memory_access_core.sv
// ----------------------------------------------------------------------------
// sized_endian_memory_access_core
// Byte-addressed memory: one sized read/write beat per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req_ channel as valid/ready beats carrying the kind,
// size, address and write data. Each request yields exactly one response beat
// on the rsp_ channel with the read data and a status code.
// The store is split into four byte-lane RAMs addressed by one row, so any
// aligned access touches one row and completes in a single RAM access.
// A response passes the RAM read register at acceptance, then the response
// register. Throughput is one beat per cycle while the receiver keeps up;
// each access uses the single RAM port once.
// Writes land in the RAMs at the edge the request is accepted, so a later
// read always sees them.
// When the receiver stalls, the response register holds and the RAM stage
// holds behind it; req_ready drops only when both are full.
// Reset (synchronous, active high) empties the pipeline, sets little-endian
// order and a size of the full store. Memory contents are undefined until
// written; no clearing pass is run. Configuration is written through csr_
// while no beat is in flight; this is up to the user and is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sized_endian_memory_access_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [1:0]  req_access_size,
   input  wire logic [31:0] req_address,
   input  wire logic [31:0] req_write_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_read_data,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [16:0] csr_write_data
);
   import sema_pkg::*;

   // Configuration registers.
   logic        big_endian_ff, big_endian_in;
   logic [16:0] mem_size_ff, mem_size_in;

   // Pipeline control.
   logic        a_valid_ff, a_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   ctl_type     ctl_ff, ctl_in;
   logic [31:0] rsp_read_data_ff, rsp_read_data_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic        req_fire;
   logic        rsp_adv;
   logic        a_adv;
   decode_type  dec;
   logic [LANES-1:0]      lane_we_s;
   logic [LANES-1:0][7:0] lane_bytes;
   logic [31:0] asm_data;

   // The response register frees when empty or taken; the RAM stage moves
   // into it then, and a new request can enter the RAM stage behind it.
   assign rsp_adv   = !rsp_valid_ff || rsp_ready;
   assign a_adv     = a_valid_ff && rsp_adv;
   assign req_ready = !a_valid_ff || rsp_adv;
   assign req_fire  = req_valid && req_ready;

   sema_decode u_decode (
      .kind        (req_kind),
      .access_size (req_access_size),
      .address     (req_address),
      .write_data  (req_write_data),
      .big_endian  (big_endian_ff),
      .mem_size    (mem_size_ff),
      .dec         (dec)
   );

   assign lane_we_s = dec.lane_we & {LANES{req_fire}};

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      sema_lane_ram #(
         .DEPTH (ROW_DEPTH),
         .WIDTH (8)
      ) u_ram (
         .clock (clock),
         .re    (req_fire && dec.read_go),
         .we    (lane_we_s[l]),
         .addr  (dec.row),
         .wdata (dec.lane_data[l]),
         .rdata (lane_bytes[l])
      );
   end

   sema_assemble u_assemble (
      .ctl        (ctl_ff),
      .lane_bytes (lane_bytes),
      .read_data  (asm_data)
   );

   always_comb begin
      big_endian_in = big_endian_ff;
      mem_size_in   = mem_size_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_BIG_ENDIAN: big_endian_in = csr_write_data[0];
            CSR_MEM_SIZE:   mem_size_in   = csr_write_data;
            default:        ;
         endcase
      end

      a_valid_in = req_fire ? 1'b1 : (a_adv ? 1'b0 : a_valid_ff);
      rsp_valid_in = a_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

      ctl_in = ctl_ff;
      if (req_fire) begin
         ctl_in.read_ok    = dec.read_go;
         ctl_in.size       = req_access_size;
         ctl_in.base       = req_address[1:0];
         ctl_in.big_endian = big_endian_ff;
         ctl_in.status     = dec.status;
      end

      rsp_read_data_in = a_adv ? asm_data : rsp_read_data_ff;
      rsp_status_in    = a_adv ? ctl_ff.status : rsp_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
         mem_size_ff   <= 17'd65536;
         a_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         big_endian_ff <= big_endian_in;
         mem_size_ff   <= mem_size_in;
         a_valid_ff    <= a_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ctl_ff           <= ctl_in;
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_status    = rsp_status_ff;

   // An error response never carries data.
   `ASSERT_NOW(a_err_no_data, clock, reset, rsp_valid_ff && (rsp_status_ff != ST_OK), rsp_read_data_ff == 32'd0)
   // Lane writes come only from aligned write beats.
   `ASSERT_NOW(a_we_aligned_write, clock, reset, |lane_we_s, (req_kind == KIND_WRITE) && (dec.status != ST_ALIGN))
   // An accepted beat always occupies the RAM stage next cycle.
   `ASSERT_NEXT(a_accept_fills, clock, reset, req_valid && req_ready, a_valid_ff)

endmodule

`default_nettype wire

FILE: sim/sema_access_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sema_access_checker
// Watches the request, response and register ports of the memory access
// core, keeps a byte-level shadow of the store and compares every response.
// ----------------------------------------------------------------------------

module sema_access_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  logic [1:0]  req_access_size,
   input  logic [31:0] req_address,
   input  logic [31:0] req_write_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_read_data,
   input  logic [1:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [16:0] csr_write_data,
   output int          mismatch_count,
   output int          replies_owed
);
   import sema_pkg::*;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  status;
   } access_reply_type;

   access_reply_type owed_replies[$];
   logic [7:0]       shadow_store [0:MEM_BYTES-1];
   logic             shadow_big_endian;
   logic [16:0]      shadow_mem_size;

   // Performs one access on the shadow store and returns the response it must produce.
   function automatic access_reply_type apply_access(input logic kind, input logic [1:0] size,
                                                     input logic [31:0] addr,
                                                     input logic [31:0] wdata);
      access_reply_type reply;
      logic [32:0]      limit;
      logic [32:0]      byte_addr;
      logic [1:0]       align_mask;
      int               n;
      int               i;
      int               shift;
      reply.read_data = '0;
      reply.status    = ST_OK;
      limit = (shadow_mem_size > MEM_BYTES) ? 33'(MEM_BYTES) : 33'(shadow_mem_size);
      if (size == SZ_RSVD) begin
         reply.status = ST_ALIGN;
         return reply;
      end
      n          = 1 << size;
      align_mask = 2'(n - 1);
      if (kind == KIND_READ) begin
         if ({1'b0, addr} + 33'(n - 1) >= limit) begin
            reply.status = ST_RANGE;
         end else if ((addr[1:0] & align_mask) != 2'd0) begin
            reply.status = ST_ALIGN;
         end else begin
            for (i = 0; i < n; i++) begin
               shift = 8 * (shadow_big_endian ? (n - 1 - i) : i);
               reply.read_data |= 32'(shadow_store[addr[15:0] + i]) << shift;
            end
         end
      end else begin
         if ((addr[1:0] & align_mask) != 2'd0) begin
            reply.status = ST_ALIGN;
         end else begin
            // Bytes inside the range are kept even when the tail falls outside.
            for (i = 0; i < n; i++) begin
               shift     = 8 * (shadow_big_endian ? (n - 1 - i) : i);
               byte_addr = {1'b0, addr} + 33'(i);
               if (byte_addr < limit) begin
                  shadow_store[byte_addr[15:0]] = 8'(wdata >> shift);
               end else begin
                  reply.status = ST_RANGE;
               end
            end
         end
      end
      return reply;
   endfunction

   always @(posedge clock) begin
      access_reply_type want;
      if (reset) begin
         shadow_big_endian = 1'b0;
         shadow_mem_size   = 17'(MEM_BYTES);
         owed_replies.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BIG_ENDIAN: shadow_big_endian = csr_write_data[0];
               CSR_MEM_SIZE:   shadow_mem_size   = csr_write_data;
               default:        ;
            endcase
         end
         if (req_valid && req_ready) begin
            owed_replies.push_back(apply_access(req_kind, req_access_size, req_address,
                                                req_write_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_replies.size() == 0) begin
               $error("response beat with nothing outstanding: read_data %h status %0d",
                      rsp_read_data, rsp_status);
               mismatch_count++;
            end else begin
               want = owed_replies.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data: expected %h, actual %h", want.read_data, rsp_read_data);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
      end
      replies_owed = owed_replies.size();
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sized reads and writes into the memory access core under both byte
// orders and a range of memory sizes, with random stalls on both channels.
// A separate checker predicts and compares every response beat.
// ----------------------------------------------------------------------------

module testbench;
   import sema_pkg::*;

   localparam int IDLE_LIMIT       = 1000;
   localparam int HOLD_OFF_CYCLES  = 200;
   localparam int PHASES           = 10;
   localparam int ITEMS_PER_PHASE  = 80;

   // Register settings walked through by the random part, extremes included.
   localparam int PHASE_BIG_ENDIAN [PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1, 1, 0};
   localparam int PHASE_MEM_SIZE   [PHASES] =
      '{65536, 65536, 131071, 4096, 1, 0, 6, 65535, 131071, 64};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_kind;
   logic [1:0]  req_access_size;
   logic [31:0] req_address;
   logic [31:0] req_write_data;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_read_data;
   logic [1:0]  rsp_status;
   logic        csr_write_enable;
   logic        csr_index;
   logic [16:0] csr_write_data;

   int          mismatch_count;
   int          replies_owed;

   // Number of long receiver hold-offs requested by the stimulus process.
   int          hold_off_asked = 0;

   // The stimulus side remembers which bytes have been written, so it never
   // issues an in-range aligned read of a byte whose content is undefined.
   bit          written_bytes [MEM_BYTES];
   logic [16:0] size_in_use = 17'(MEM_BYTES);
   bit          eager = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sized_endian_memory_access_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_access_size  (req_access_size),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   sema_access_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_access_size  (req_access_size),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .replies_owed     (replies_owed)
   );

   // Bytes actually in use; a size register above the store acts as the store.
   function automatic longint active_limit();
      return (size_in_use > MEM_BYTES) ? longint'(MEM_BYTES) : longint'(size_in_use);
   endfunction

   // Offers one request beat and returns at the edge where it is accepted.
   // It is entered at a rising edge, so a zero gap keeps valid high across
   // back-to-back beats with a single assignment in that time step.
   task automatic issue_access(input logic kind, input logic [1:0] size,
                               input logic [31:0] addr, input logic [31:0] data);
      logic   k;
      int     n;
      int     i;
      int     gap;
      int     r;
      longint limit;
      k = kind;
      if (size != SZ_RSVD) begin
         n     = 1 << size;
         limit = active_limit();
         // A read that would return undefined bytes is turned into a write of
         // the same place, which also makes later reads there legal.
         if (k == KIND_READ && longint'(addr) + n - 1 < limit && (addr & (n - 1)) == 0) begin
            for (i = 0; i < n; i++) begin
               if (!written_bytes[addr[15:0] + i]) begin
                  k = KIND_WRITE;
               end
            end
         end
         if (k == KIND_WRITE && (addr & (n - 1)) == 0) begin
            for (i = 0; i < n; i++) begin
               if (longint'(addr) + i < limit) begin
                  written_bytes[addr[15:0] + i] = 1'b1;
               end
            end
         end
      end
      // Mostly short gaps, now and then a long one, none at all while eager.
      r = $urandom_range(0, 99);
      if (eager || r < 55) begin
         gap = 0;
      end else if (r < 88) begin
         gap = $urandom_range(1, 3);
      end else if (r < 97) begin
         gap = $urandom_range(4, 10);
      end else begin
         gap = $urandom_range(20, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= k;
      req_access_size <= size;
      req_address     <= addr;
      req_write_data  <= data;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops offering beats and waits until every response has come back, then
   // lets the pipeline settle. The response count is read at the falling edge
   // so it never races the checker's update.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(negedge clock); while (replies_owed != 0);
      repeat (4) @(posedge clock);
   endtask

   // Registers are only written with the core idle.
   task automatic write_csr(input logic index, input logic [16:0] value);
      drain_pipeline();
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_MEM_SIZE) begin
         size_in_use = value;
      end
   endtask

   // Response side: windows of steady or random readiness, an occasional long
   // stall, and the long hold-off that the stimulus side asks for. A request
   // for the hold-off cuts the current window short, so the hold-off starts
   // while the sender is still offering beats.
   initial begin : response_sink
      int hold_off_taken;
      int window;
      int mode;
      hold_off_taken = 0;
      forever begin
         if (hold_off_taken != hold_off_asked) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_taken++;
         end else begin
            mode   = $urandom_range(0, 3);
            window = $urandom_range(16, 96);
            repeat (window) begin
               if (hold_off_taken != hold_off_asked) begin
                  break;
               end
               case (mode)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= ($urandom_range(0, 3) != 0);
                  2:       rsp_ready <= 1'($urandom_range(0, 1));
                  default: rsp_ready <= ($urandom_range(0, 19) != 0);
               endcase
               @(posedge clock);
            end
            if (hold_off_taken == hold_off_asked && $urandom_range(0, 11) == 0) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(12, 48)) @(posedge clock);
            end
         end
      end
   end

   // Ends the run when neither channel has moved a beat for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int          phase;
      int          item;
      int          r;
      longint      limit;
      logic [1:0]  sz;
      logic [1:0]  rd_sz;
      logic [1:0]  align_mask;
      logic [31:0] addr;
      logic [31:0] data;
      logic        k;
      bit          hold_armed;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_kind         <= KIND_READ;
      req_access_size  <= SZ_BYTE;
      req_address      <= '0;
      req_write_data   <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_BIG_ENDIAN;
      csr_write_data   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, starting from the reset settings: little-endian order
      // over the whole store.
      issue_access(KIND_WRITE, SZ_WORD, 32'h0000_0000, 32'h1122_3344);
      issue_access(KIND_READ,  SZ_WORD, 32'h0000_0000, 32'h0000_0000);
      issue_access(KIND_READ,  SZ_HALF, 32'h0000_0002, 32'hFFFF_FFFF);
      issue_access(KIND_READ,  SZ_BYTE, 32'h0000_0001, 32'h0000_0000);
      // Only the low half of the write data may land in memory.
      issue_access(KIND_WRITE, SZ_HALF, 32'h0000_0006, 32'hFFFF_ABCD);
      issue_access(KIND_READ,  SZ_HALF, 32'h0000_0006, 32'h0000_0000);
      // Misaligned word and halfword reads with every byte in range.
      issue_access(KIND_READ,  SZ_WORD, 32'h0000_0002, 32'h0000_0000);
      issue_access(KIND_READ,  SZ_HALF, 32'h0000_0001, 32'h0000_0000);
      // A misaligned write stores nothing.
      issue_access(KIND_WRITE, SZ_WORD, 32'h0000_0011, 32'hFFFF_FFFF);
      // The reserved access size, for both kinds.
      issue_access(KIND_READ,  SZ_RSVD, 32'h0000_0000, 32'h0000_0000);
      issue_access(KIND_WRITE, SZ_RSVD, 32'h0000_0000, 32'hFFFF_FFFF);
      // The last word of the store, then accesses that run past its end.
      issue_access(KIND_WRITE, SZ_WORD, 32'h0000_FFFC, 32'hDEAD_BEEF);
      issue_access(KIND_READ,  SZ_WORD, 32'h0000_FFFC, 32'h0000_0000);
      issue_access(KIND_READ,  SZ_BYTE, 32'h0000_FFFF, 32'h0000_0000);
      issue_access(KIND_READ,  SZ_WORD, 32'h0000_FFFE, 32'h0000_0000);
      issue_access(KIND_READ,  SZ_BYTE, 32'h0001_0000, 32'h0000_0000);
      issue_access(KIND_WRITE, SZ_BYTE, 32'h0001_0000, 32'h0000_00AA);
      // At the top of the address space the range check must not wrap.
      issue_access(KIND_WRITE, SZ_WORD, 32'hFFFF_FFFC, 32'h5A5A_5A5A);
      issue_access(KIND_READ,  SZ_HALF, 32'hFFFF_FFFF, 32'h0000_0000);

      // Big-endian order over the same bytes.
      write_csr(CSR_BIG_ENDIAN, 17'd1);
      issue_access(KIND_READ,  SZ_WORD, 32'h0000_0000, 32'h0000_0000);
      issue_access(KIND_WRITE, SZ_HALF, 32'h0000_0008, 32'h0000_1234);
      issue_access(KIND_READ,  SZ_BYTE, 32'h0000_0008, 32'h0000_0000);

      // A small size makes a word write straddle the end: a partial write.
      write_csr(CSR_MEM_SIZE, 17'd6);
      issue_access(KIND_WRITE, SZ_WORD, 32'h0000_0004, 32'hCAFE_F00D);
      issue_access(KIND_READ,  SZ_HALF, 32'h0000_0004, 32'h0000_0000);
      issue_access(KIND_READ,  SZ_WORD, 32'h0000_0004, 32'h0000_0000);

      // Random part, one phase per register setting. Each register change
      // drains the core first, so the sender also pauses until everything
      // has come back.
      for (phase = 0; phase < PHASES; phase++) begin
         write_csr(CSR_BIG_ENDIAN, 17'(PHASE_BIG_ENDIAN[phase]));
         write_csr(CSR_MEM_SIZE, 17'(PHASE_MEM_SIZE[phase]));
         hold_armed = (phase == 0 || phase == 6);
         item = 0;
         while (item < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 31) == 0) begin
               eager = ($urandom_range(0, 2) == 0);
            end
            // Ask for the long hold-off and keep offering beats without gaps,
            // so the core fills up and drops req_ready.
            if (hold_armed && item >= 30) begin
               hold_off_asked <= hold_off_asked + 1;
               eager = 1'b1;
               hold_armed = 1'b0;
            end

            r  = $urandom_range(0, 99);
            sz = (r < 31) ? SZ_BYTE : (r < 62) ? SZ_HALF : (r < 93) ? SZ_WORD : SZ_RSVD;

            // Most addresses land near the bottom or near the end of the
            // range in use, where bytes get written and read back; the rest
            // spread over the whole range or the whole address space.
            limit = active_limit();
            r     = $urandom_range(0, 99);
            if (limit == 0 || r >= 85) begin
               addr = $urandom;
            end else if (r < 45) begin
               addr = $urandom_range(0, (limit < 64) ? int'(limit - 1) : 63);
            end else if (r < 70) begin
               addr = 32'(limit - $urandom_range(1, (limit < 8) ? int'(limit) : 8));
            end else begin
               addr = $urandom_range(0, int'(limit - 1));
            end
            if (sz != SZ_RSVD && $urandom_range(0, 99) < 85) begin
               align_mask = 2'((1 << sz) - 1);
               addr[1:0]  = addr[1:0] & ~align_mask;
            end

            r    = $urandom_range(0, 99);
            data = (r < 8) ? 32'h0000_0000 : (r < 16) ? 32'hFFFF_FFFF : 32'($urandom);

            if (sz != SZ_RSVD && $urandom_range(0, 99) < 25) begin
               // Store followed by a read back of the same place, possibly
               // narrower than the store.
               rd_sz = 2'($urandom_range(0, sz));
               issue_access(KIND_WRITE, sz, addr, data);
               issue_access(KIND_READ, rd_sz, addr, 32'($urandom));
               item += 2;
            end else begin
               k = ($urandom_range(0, 1) == 0) ? KIND_READ : KIND_WRITE;
               issue_access(k, sz, addr, data);
               item++;
            end
         end
      end

      drain_pipeline();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
